[rtl/wsfp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the WebSocket frame parser and unmasker.
// No dependencies; imported by every module of the block.
package wsfp_pkg;

	localparam int LEN_W = 31;
	localparam int CFG_W = 7;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_RSV      = 2'd1;
	localparam logic [1:0] ERR_CTRL_LEN = 2'd2;
	localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

	// configuration register indexes
	localparam logic REG_CONTROL_LIMIT = 1'b0;
	localparam logic REG_UNMASK_ENABLE = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one classified item from the front parser to the back end
	typedef struct packed {
		logic [1:0]       kind;
		logic             fin;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] payload_length;
		logic [3:0]       hdr_bytes;
		logic [7:0]       data;
		logic [7:0]       key_byte;
		logic             last;
		logic [1:0]       error_code;
	} wsfp_cmd_t;

endpackage

[rtl/wsfp_front.sv]
`timescale 1ns / 1ps
// Front end: header parser state machine that classifies each received byte.
// Depends on wsfp_pkg; feeds wsfp_queue with wsfp_cmd_t items.
module wsfp_front import wsfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             restart,
	input  logic [CFG_W-1:0] control_limit,
	output logic             cmd_valid,
	output wsfp_cmd_t        cmd
);

	localparam logic [2:0] PH_BYTE0   = 3'd0;
	localparam logic [2:0] PH_BYTE1   = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_DISCARD = 3'd5;

	localparam logic [31:0] MAX_FRAME = 32'h7FFF_FFFF;

	logic [2:0]       phase_q, phase_d, ph;
	logic             fin_q, fin_d;
	logic [3:0]       opc_q, opc_d;
	logic             masked_q, masked_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             big_q, big_d;
	logic [2:0]       lcnt_q, lcnt_d;
	logic [31:0]      key_q, key_d;
	logic [1:0]       kidx_q, kidx_d;
	logic [LEN_W-1:0] rem_q, rem_d;
	logic [3:0]       hs_q, hs_d;

	logic        do_ld, do_hd, hd_last;
	logic [31:0] frame_sum;

	always_comb begin
		ph        = restart ? PH_BYTE0 : phase_q;
		phase_d   = ph;
		fin_d     = fin_q;
		opc_d     = opc_q;
		masked_d  = masked_q;
		len_d     = len_q;
		big_d     = big_q;
		lcnt_d    = lcnt_q;
		key_d     = key_q;
		kidx_d    = kidx_q;
		rem_d     = rem_q;
		hs_d      = hs_q;
		do_ld     = 1'b0;
		do_hd     = 1'b0;
		hd_last   = 1'b0;
		frame_sum = '0;
		cmd_valid = 1'b0;
		cmd       = '0;

		case (ph)
			PH_BYTE0: begin
				fin_d    = data_byte[7];
				opc_d    = data_byte[3:0];
				masked_d = 1'b0;
				if (data_byte[6:4] != 3'd0) begin
					phase_d        = PH_DISCARD;
					cmd_valid      = 1'b1;
					cmd.kind       = KIND_ERROR;
					cmd.error_code = ERR_RSV;
				end else begin
					phase_d = PH_BYTE1;
				end
			end
			PH_BYTE1: begin
				masked_d = data_byte[7];
				hs_d     = 4'd2;
				big_d    = 1'b0;
				if (data_byte[6:0] < 7'd126) begin
					len_d = {{(LEN_W-7){1'b0}}, data_byte[6:0]};
					do_ld = 1'b1;
				end else begin
					len_d = '0;
					// eight length bytes wrap to zero in the three-bit count
					lcnt_d  = (data_byte[6:0] == 7'd126) ? 3'd2 : 3'd0;
					hs_d    = (data_byte[6:0] == 7'd126) ? 4'd4 : 4'd10;
					phase_d = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				big_d  = big_q | (len_q[LEN_W-1:LEN_W-8] != 8'd0);
				len_d  = {len_q[LEN_W-9:0], data_byte};
				lcnt_d = lcnt_q - 3'd1;
				do_ld  = (lcnt_d == 3'd0);
			end
			PH_KEY: begin
				key_d  = {key_q[23:0], data_byte};
				kidx_d = kidx_q + 2'd1;
				do_hd  = (kidx_d == 2'd0);
			end
			PH_PAYLOAD: begin
				rem_d          = rem_q - LEN_W'(1);
				kidx_d         = kidx_q + 2'd1;
				cmd_valid      = 1'b1;
				cmd.kind       = KIND_PAYLOAD;
				cmd.payload_length = len_q;
				cmd.hdr_bytes      = hs_q;
				cmd.data       = data_byte;
				cmd.key_byte   = 8'(key_q >> {~kidx_q, 3'b000});
				cmd.last       = (rem_d == '0);
				if (rem_d == '0)
					phase_d = PH_BYTE0;
			end
			default: begin
				// drop everything until restart
			end
		endcase

		// length complete: control check first, then total frame size
		if (do_ld) begin
			if (opc_d[3] && (big_d || len_d > LEN_W'(control_limit))) begin
				phase_d        = PH_DISCARD;
				cmd_valid      = 1'b1;
				cmd.kind       = KIND_ERROR;
				cmd.error_code = ERR_CTRL_LEN;
			end else begin
				hs_d      = hs_d + (masked_d ? 4'd4 : 4'd0);
				frame_sum = {1'b0, len_d} + 32'(hs_d);
				if (big_d || frame_sum > MAX_FRAME) begin
					phase_d        = PH_DISCARD;
					cmd_valid      = 1'b1;
					cmd.kind       = KIND_ERROR;
					cmd.error_code = ERR_TOO_BIG;
				end else if (masked_d) begin
					phase_d = PH_KEY;
					kidx_d  = 2'd0;
				end else begin
					do_hd = 1'b1;
				end
			end
		end

		if (do_hd) begin
			hd_last            = (len_d == '0);
			rem_d              = len_d;
			kidx_d             = 2'd0;
			phase_d            = hd_last ? PH_BYTE0 : PH_PAYLOAD;
			cmd_valid          = 1'b1;
			cmd.kind           = KIND_HEADER;
			cmd.payload_length = len_d;
			cmd.hdr_bytes      = hs_d;
			cmd.last           = hd_last;
		end

		cmd.fin    = fin_d;
		cmd.opcode = opc_d;
		cmd.masked = masked_d;
		if (cmd.kind == KIND_ERROR)
			cmd.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BYTE0;
			fin_q    <= 1'b0;
			opc_q    <= 4'd0;
			masked_q <= 1'b0;
			len_q    <= '0;
			big_q    <= 1'b0;
			lcnt_q   <= 3'd0;
			key_q    <= 32'd0;
			kidx_q   <= 2'd0;
			rem_q    <= '0;
			hs_q     <= 4'd2;
		end else if (accept) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opc_q    <= opc_d;
			masked_q <= masked_d;
			len_q    <= len_d;
			big_q    <= big_d;
			lcnt_q   <= lcnt_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
			rem_q    <= rem_d;
			hs_q     <= hs_d;
		end
	end

endmodule

[rtl/wsfp_queue.sv]
`timescale 1ns / 1ps
// Short item queue between the front parser and the back end.
// Depends on wsfp_pkg for wsfp_cmd_t and the queue depth.
module wsfp_queue import wsfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  wsfp_cmd_t wr_data,
	output logic      full,
	input  logic      rd,
	output wsfp_cmd_t rd_data,
	output logic      empty
);

	wsfp_cmd_t         mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({wr, rd})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/wsfp_back.sv]
`timescale 1ns / 1ps
// Back end: unmasks payload bytes, forms the frame length, holds the result register.
// Depends on wsfp_pkg; drains wsfp_queue.
module wsfp_back import wsfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             unmask_enable,
	input  logic             q_empty,
	input  wsfp_cmd_t        q_data,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic             fin,
	output logic [3:0]       opcode,
	output logic             masked,
	output logic [LEN_W-1:0] payload_length,
	output logic [LEN_W-1:0] frame_length,
	output logic [7:0]       payload_byte,
	output logic             last,
	output logic [1:0]       error_code
);

	logic valid_q;
	logic xor_en;

	assign empty  = !valid_q;
	// refill when the result register is free or being taken
	assign q_rd   = !q_empty && (!valid_q || pop);
	assign xor_en = (q_data.kind == KIND_PAYLOAD) && q_data.masked && unmask_enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_rd)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			kind           <= q_data.kind;
			fin            <= q_data.fin;
			opcode         <= q_data.opcode;
			masked         <= q_data.masked;
			payload_length <= q_data.payload_length;
			frame_length   <= (q_data.kind == KIND_ERROR) ? '0 :
				q_data.payload_length + LEN_W'(q_data.hdr_bytes);
			payload_byte   <= q_data.data ^ (xor_en ? q_data.key_byte : 8'd0);
			last           <= q_data.last;
			error_code     <= q_data.error_code;
		end
	end

endmodule

[rtl/websocket_frame_parser_unmask_top.sv]
`timescale 1ns / 1ps
// WebSocket receive-side frame parser with payload unmasking: top level.
// Depends on wsfp_pkg, wsfp_front, wsfp_queue and wsfp_back.
//
// Takes one stream byte per cycle (push while full is low) and yields at most
// one result per byte: a header result once the length and mask key are in,
// one result per payload byte, or an error, after which input is dropped until
// a byte arrives with restart set. The parser decides in the cycle a byte is
// taken; its item goes through a four-entry queue into a result register, and
// the block keeps taking one byte per cycle while pop keeps up. full rises only
// when the queue and result register are both held by a stalled reader.
// Configuration writes take effect on the next cycle and belong in idle periods.
module websocket_frame_parser_unmask_top import wsfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       data_byte,
	input  logic             restart,
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       kind,
	output logic             fin,
	output logic [3:0]       opcode,
	output logic             masked,
	output logic [LEN_W-1:0] payload_length,
	output logic [LEN_W-1:0] frame_length,
	output logic [7:0]       payload_byte,
	output logic             last,
	output logic [1:0]       error_code,
	input  logic             cfg_wr_en,
	input  logic             cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0] control_limit_q;
	logic             unmask_enable_q;

	logic      accept;
	logic      cmd_valid;
	wsfp_cmd_t cmd;
	logic      q_rd, q_empty;
	wsfp_cmd_t q_data;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_limit_q <= CFG_W'(125);
			unmask_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_CONTROL_LIMIT: control_limit_q <= cfg_wdata;
				REG_UNMASK_ENABLE: unmask_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	wsfp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.restart       (restart),
		.control_limit (control_limit_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd)
	);

	wsfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept && cmd_valid),
		.wr_data (cmd),
		.full    (full),
		.rd      (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	wsfp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.unmask_enable  (unmask_enable_q),
		.q_empty        (q_empty),
		.q_data         (q_data),
		.q_rd           (q_rd),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.fin            (fin),
		.opcode         (opcode),
		.masked         (masked),
		.payload_length (payload_length),
		.frame_length   (frame_length),
		.payload_byte   (payload_byte),
		.last           (last),
		.error_code     (error_code)
	);

endmodule

[rtl/wsfp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result stream of the frame parser, bound to the top level.
// Depends on wsfp_pkg for result kinds and error codes.
module wsfp_checker import wsfp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [1:0]       kind,
	input logic [LEN_W-1:0] payload_length,
	input logic [LEN_W-1:0] frame_length,
	input logic [7:0]       payload_byte,
	input logic             last,
	input logic [1:0]       error_code
);

	// an error result closes the frame and carries no lengths
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ERROR) |->
			(last && frame_length == '0 && payload_length == '0 && error_code != ERR_NONE))
		else $error("malformed error result");

	// header results cover at least the two fixed header bytes
	a_header_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_HEADER) |->
			({1'b0, frame_length} >= {1'b0, payload_length} + 32'd2 &&
			 error_code == ERR_NONE && payload_byte == 8'd0))
		else $error("header result lengths inconsistent");

	// a payload byte only exists in a frame with a nonzero length
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_PAYLOAD) |->
			(payload_length != '0 && error_code == ERR_NONE))
		else $error("payload result without payload length");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(payload_byte)))
		else $error("result changed before pop");

endmodule

bind websocket_frame_parser_unmask_top wsfp_checker u_wsfp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.kind           (kind),
	.payload_length (payload_length),
	.frame_length   (frame_length),
	.payload_byte   (payload_byte),
	.last           (last),
	.error_code     (error_code)
);

[tb/websocket_frame_parser_unmask_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_parser_unmask_top: feeds WebSocket byte
// streams and checks every header, payload and error item against a built-in parser.
// Depends on wsfp_pkg and the RTL of the block only.
module websocket_frame_parser_unmask_top_test;
	import wsfp_pkg::*;

	localparam logic [3:0]  OP_CONT   = 4'h0;
	localparam logic [3:0]  OP_TEXT   = 4'h1;
	localparam logic [3:0]  OP_BINARY = 4'h2;
	localparam logic [3:0]  OP_CLOSE  = 4'h8;
	localparam logic [3:0]  OP_PING   = 4'h9;
	localparam logic [3:0]  OP_PONG   = 4'hA;
	localparam logic [63:0] MAX_FRAME = 64'h7FFF_FFFF;
	localparam int          DRAIN_CYCLES = 12;

	typedef enum logic [2:0] {HDR0, HDR1, EXT_LEN, KEY, BODY, DROP} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       rst;
	} stream_byte_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             fin;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] payload_length;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       payload_byte;
		logic             last;
		logic [1:0]       error_code;
	} frame_result_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             push      = 1'b0;
	logic [7:0]       data_byte = 8'h00;
	logic             restart   = 1'b0;
	logic             pop       = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic             cfg_addr  = REG_CONTROL_LIMIT;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             full;
	logic             empty;
	logic [1:0]       kind;
	logic             fin;
	logic [3:0]       opcode;
	logic             masked;
	logic [LEN_W-1:0] payload_length;
	logic [LEN_W-1:0] frame_length;
	logic [7:0]       payload_byte;
	logic             last;
	logic [1:0]       error_code;

	websocket_frame_parser_unmask_top dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .data_byte(data_byte), .restart(restart),
		.empty(empty), .pop(pop),
		.kind(kind), .fin(fin), .opcode(opcode), .masked(masked),
		.payload_length(payload_length), .frame_length(frame_length),
		.payload_byte(payload_byte), .last(last), .error_code(error_code),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// parser state and register copies
	parse_phase_t phase_q;
	logic [63:0]  len_acc;
	logic [3:0]   ext_left;
	logic [31:0]  key_word;
	logic [1:0]   key_idx;
	logic [30:0]  bytes_left;
	logic         hdr_fin;
	logic [3:0]   hdr_op;
	logic         hdr_masked;
	logic [3:0]   hdr_size;
	logic [6:0]   ctrl_limit;
	logic         unmask_on;

	stream_byte_t  pending_bytes[$];
	frame_result_t due_results[$];
	int            mismatch_count = 0;
	int            bytes_queued = 0;
	int            send_gap = 0;
	int            take_gap = 0;
	int            send_gap_div = 0;
	int            recv_gap_div = 0;
	bit            resync_due = 1'b0;

	task automatic reset_frame_state();
		phase_q    = HDR0;
		len_acc    = '0;
		ext_left   = '0;
		key_word   = '0;
		key_idx    = '0;
		bytes_left = '0;
		hdr_fin    = 1'b0;
		hdr_op     = '0;
		hdr_masked = 1'b0;
		hdr_size   = 4'd2;
	endtask

	task automatic queue_result(input logic [1:0] k, input logic [63:0] plen,
			input logic [63:0] flen, input logic [7:0] pb, input logic lst,
			input logic [1:0] err);
		frame_result_t r;
		r.kind           = k;
		r.fin            = hdr_fin;
		r.opcode         = hdr_op;
		r.masked         = hdr_masked;
		r.payload_length = plen[LEN_W-1:0];
		r.frame_length   = flen[LEN_W-1:0];
		r.payload_byte   = pb;
		r.last           = lst;
		r.error_code     = err;
		due_results.push_back(r);
	endtask

	task automatic flag_error(input logic [1:0] err);
		phase_q = DROP;
		queue_result(KIND_ERROR, '0, '0, 8'h00, 1'b1, err);
	endtask

	task automatic finish_header();
		logic [63:0] total;
		total = 64'(hdr_size) + len_acc;
		queue_result(KIND_HEADER, len_acc, total, 8'h00, len_acc == 0, ERR_NONE);
		key_idx = '0;
		if (len_acc == 0) begin
			reset_frame_state();
		end else begin
			bytes_left = len_acc[30:0];
			phase_q = BODY;
		end
	endtask

	// control length first, then total size with the key counted
	task automatic check_length();
		if (hdr_op >= OP_CLOSE && len_acc > 64'(ctrl_limit)) begin
			flag_error(ERR_CTRL_LEN);
			return;
		end
		if (hdr_masked)
			hdr_size = hdr_size + 4'd4;
		if (len_acc > MAX_FRAME - 64'(hdr_size)) begin
			flag_error(ERR_TOO_BIG);
		end else if (hdr_masked) begin
			phase_q = KEY;
			key_idx = '0;
		end else begin
			finish_header();
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic rst);
		logic [7:0]  v;
		logic [63:0] total;
		if (rst)
			reset_frame_state();
		case (phase_q)
			HDR0: begin
				hdr_fin    = b[7];
				hdr_op     = b[3:0];
				hdr_masked = 1'b0;
				if (b[6:4] != 3'b000)
					flag_error(ERR_RSV);
				else
					phase_q = HDR1;
			end
			HDR1: begin
				hdr_masked = b[7];
				hdr_size   = 4'd2;
				len_acc    = '0;
				if (b[6:0] < 7'd126) begin
					len_acc = 64'(b[6:0]);
					check_length();
				end else begin
					ext_left = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
					hdr_size = hdr_size + ext_left;
					phase_q  = EXT_LEN;
				end
			end
			EXT_LEN: begin
				len_acc  = {len_acc[55:0], b};
				ext_left = ext_left - 4'd1;
				if (ext_left == 0)
					check_length();
			end
			KEY: begin
				key_word = {key_word[23:0], b};
				key_idx  = key_idx + 2'd1;
				if (key_idx == 0)
					finish_header();
			end
			BODY: begin
				v = b;
				if (hdr_masked && unmask_on)
					v = v ^ 8'(key_word >> (24 - 8 * int'(key_idx)));
				key_idx    = key_idx + 2'd1;
				bytes_left = bytes_left - 31'd1;
				total      = 64'(hdr_size) + len_acc;
				queue_result(KIND_PAYLOAD, len_acc, total, v, bytes_left == 0, ERR_NONE);
				if (bytes_left == 0)
					reset_frame_state();
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want_v);
		if (got !== want_v)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want_v));
	endtask

	task automatic check_result();
		frame_result_t want;
		if (due_results.size() == 0) begin
			report_mismatch("result item with nothing expected");
			return;
		end
		want = due_results.pop_front();
		check_field("kind", kind, want.kind);
		check_field("fin", fin, want.fin);
		check_field("opcode", opcode, want.opcode);
		check_field("masked", masked, want.masked);
		check_field("payload_length", payload_length, want.payload_length);
		check_field("frame_length", frame_length, want.frame_length);
		check_field("payload_byte", payload_byte, want.payload_byte);
		check_field("last", last, want.last);
		check_field("error_code", error_code, want.error_code);
	endtask

	// sender: advance on acceptance, idle in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				parse_byte(data_byte, restart);
				void'(pending_bytes.pop_front());
			end
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (pending_bytes.size() == 0) begin
				push <= 1'b0;
			end else if (send_gap_div != 0 && $urandom_range(1, send_gap_div) == 1) begin
				send_gap = $urandom_range(0, 9);
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				data_byte <= pending_bytes[0].data;
				restart <= pending_bytes[0].rst;
			end
		end
	end

	// receiver: check each accepted item, stall in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_result();
			if (take_gap > 0) begin
				take_gap--;
				pop <= 1'b0;
			end else if (recv_gap_div != 0 && $urandom_range(1, recv_gap_div) == 1) begin
				take_gap = $urandom_range(0, 9);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] data, input logic rst);
		stream_byte_t s;
		s.data = data;
		s.rst  = rst;
		pending_bytes.push_back(s);
		bytes_queued++;
	endtask

	// enc: 0 seven-bit length, 1 sixteen-bit, 2 sixty-four-bit
	task automatic queue_frame(input logic [7:0] b0, input logic mbit, input int enc,
			input logic [63:0] len, input int body, input logic rst0);
		logic [6:0] code;
		code = (enc == 0) ? len[6:0] : ((enc == 1) ? 7'd126 : 7'd127);
		queue_byte(b0, rst0);
		queue_byte({mbit, code}, 1'b0);
		if (enc == 1)
			for (int i = 1; i >= 0; i--)
				queue_byte(len[8*i +: 8], 1'b0);
		if (enc == 2)
			for (int i = 7; i >= 0; i--)
				queue_byte(len[8*i +: 8], 1'b0);
		if (mbit)
			repeat (4) queue_byte(8'($urandom), 1'b0);
		repeat (body) queue_byte(8'($urandom), 1'b0);
	endtask

	task automatic queue_random_frame();
		int          pick;
		int          enc;
		int          body;
		int          r;
		logic [63:0] len;
		logic [3:0]  op;
		logic [2:0]  rsv;
		logic        mbit;
		logic        rst0;
		pick = $urandom_range(0, 99);
		rst0 = resync_due || ($urandom_range(0, 7) == 0);
		resync_due = 1'b0;
		op   = 4'($urandom_range(0, 15));
		mbit = 1'($urandom_range(0, 1));
		rsv  = 3'b000;
		len  = 64'($urandom_range(0, 24));
		if ($urandom_range(0, 19) == 0)
			len = 64'($urandom_range(126, 300));
		if (op >= OP_CLOSE && len > 64'(ctrl_limit))
			len = 64'($urandom_range(0, ctrl_limit));
		body = int'(len);
		// broken frames, followed by a restart; an error makes the block drop input until then
		if (pick >= 80) begin
			resync_due = 1'b1;
			body = $urandom_range(0, 3);
			case (pick % 5)
				0: rsv = 3'($urandom_range(1, 7));
				1: begin
					op  = 4'($urandom_range(8, 15));
					len = 64'(ctrl_limit) + 64'd1 + 64'($urandom_range(0, 200));
				end
				2: begin
					op[3] = 1'b0;
					if ($urandom_range(0, 1))
						len = {32'($urandom), 32'($urandom)} | 64'h8000_0000;
					else
						len = MAX_FRAME - (mbit ? 64'd14 : 64'd10) + 64'($urandom_range(0, 1));
				end
				3: body = (len > 0) ? $urandom_range(0, int'(len) - 1) : 0;
				default: begin
					repeat ($urandom_range(1, 6))
						queue_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
					return;
				end
			endcase
		end
		if (len > 64'hFFFF) begin
			enc = 2;
		end else if (len > 125) begin
			enc = $urandom_range(1, 2);
		end else begin
			r = $urandom_range(0, 9);
			enc = (r < 7) ? 0 : ((r < 9) ? 1 : 2);
		end
		queue_frame({1'($urandom_range(0, 1)), rsv, op}, mbit, enc, len, body, rst0);
	endtask

	task automatic write_reg(input logic addr, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (addr == REG_CONTROL_LIMIT)
			ctrl_limit = value;
		else
			unmask_on = value[0];
		@(posedge clk);
	endtask

	// hold the sender until every expected item is back and the pipe is quiet
	task automatic wait_idle();
		while (pending_bytes.size() != 0)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_gap_div();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 4;
			2: return 12;
			default: return 40;
		endcase
	endfunction

	initial begin
		int         base;
		logic [6:0] lim;
		logic       en;
		ctrl_limit = 7'd125;
		unmask_on  = 1'b1;
		reset_frame_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_div = 6;
		recv_gap_div = 6;
		queue_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, 0, 64'd0, 0, 1'b1);
		queue_frame({1'b0, 3'b000, OP_BINARY}, 1'b1, 0, 64'd3, 3, 1'b0);
		queue_frame({1'b0, 3'b000, OP_CONT}, 1'b0, 1, 64'd2, 2, 1'b0);
		// reserved bits, then a dropped byte
		queue_frame({1'b1, 3'b111, OP_TEXT}, 1'b0, 0, 64'd2, 0, 1'b0);
		queue_frame({1'b1, 3'b000, OP_PING}, 1'b1, 1, 64'd126, 0, 1'b1);
		// control length at the limit, cut short by the next restart
		queue_frame({1'b1, 3'b000, OP_PONG}, 1'b0, 0, 64'd125, 3, 1'b1);
		queue_frame({1'b1, 3'b000, OP_BINARY}, 1'b0, 2, MAX_FRAME - 64'd10, 0, 1'b1);
		queue_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 2, MAX_FRAME - 64'd13, 0, 1'b1);
		queue_frame({1'b1, 3'b000, OP_CLOSE}, 1'b0, 2, '1, 0, 1'b1);
		queue_frame({1'b0, 3'b000, OP_TEXT}, 1'b0, 2, '1, 0, 1'b1);
		queue_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, 0, 64'd5, 5, 1'b1);
		wait_idle();

		write_reg(REG_CONTROL_LIMIT, 7'd0);
		write_reg(REG_UNMASK_ENABLE, 7'd0);
		queue_frame({1'b1, 3'b000, OP_PING}, 1'b0, 0, 64'd0, 0, 1'b1);
		queue_frame({1'b1, 3'b000, OP_PONG}, 1'b0, 0, 64'd1, 0, 1'b0);
		queue_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 0, 64'd4, 4, 1'b1);
		queue_frame({1'b1, 3'b000, OP_CLOSE}, 1'b1, 2, 64'd0, 0, 1'b0);
		wait_idle();

		resync_due = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			lim = 7'($urandom_range(1, 124));
			en  = 1'($urandom_range(0, 1));
			case (ph)
				0: begin
					lim = 7'd125;
					en  = 1'b1;
				end
				2: lim = 7'd0;
				5: lim = 7'd125;
				default: ;
			endcase
			write_reg(REG_CONTROL_LIMIT, lim);
			write_reg(REG_UNMASK_ENABLE, 7'(en));
			// no idling at all in the last part of the run
			send_gap_div = (ph == 5) ? 0 : pick_gap_div();
			recv_gap_div = (ph == 5) ? 0 : pick_gap_div();
			base = bytes_queued;
			while (bytes_queued - base < 160)
				queue_random_frame();
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("websocket_frame_parser_unmask_top verification clean");
		else
			$display("websocket_frame_parser_unmask_top verification failed");
		$finish;
	end

	// slowest legal run is well under a millisecond; allow several times that
	initial begin
		#5_000_000;
		$display("websocket_frame_parser_unmask_top verification failed");
		$finish;
	end

endmodule
